// File: rtl/multiplexed_alarm_scheduler_top_assert.svh
// Assertion macros for the multiplexed alarm scheduler.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef MULTIPLEXED_ALARM_SCHEDULER_TOP_ASSERT_SVH
`define MULTIPLEXED_ALARM_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define MASCH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MASCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/masch_pkg.sv
// Shared constants, types and helpers for the multiplexed alarm scheduler.
// No dependencies.
package masch_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int TIME_W   = 32;
    localparam int IDX_W    = 4;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 40;

    localparam logic [TIME_W-1:0] NO_ALARM = '1;

    localparam logic ERR_INVALID = 1'b0;
    localparam logic ERR_NO_SLOT = 1'b1;

    typedef enum logic [2:0] {
        ACT_REGISTER   = 3'd0,
        ACT_ENABLE     = 3'd1,
        ACT_DISABLE    = 3'd2,
        ACT_UPDATE     = 3'd3,
        ACT_TICK       = 3'd4,
        ACT_SET_KERNEL = 3'd5,
        ACT_FIRE_ALL   = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        KIND_ACK   = 3'd0,
        KIND_ERROR = 3'd1,
        KIND_FIRED = 3'd2,
        KIND_SLEEP = 3'd3,
        KIND_PROG  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG_SCAN,
        ST_SINGLE,
        ST_SLEEP,
        ST_SCAN,
        ST_FLUSH,
        ST_PROG
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic              error_code;
        logic [IDX_W-1:0]  task_index_res;
        logic [TIME_W-1:0] alarm_time;
        logic              alarm_enable;
        logic              last;
    } res_t;

    function automatic logic [IDX_W-1:0] slot_to_res(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, s};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] i);
        logic [SLOT_W+IDX_W-1:0] w;
        w = {{SLOT_W{1'b0}}, i};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic idx_in_range(input logic [IDX_W-1:0] i);
        logic [SLOT_W+IDX_W:0] w;
        w = {{(SLOT_W+1){1'b0}}, i};
        return w < (SLOT_W+IDX_W+1)'(SLOTS);
    endfunction

endpackage

// File: rtl/multiplexed_alarm_scheduler_top.sv
// Multiplexed alarm scheduler top level: command decode, slot flags, scan sequencer.
// Depends on masch_pkg, masch_ram, masch_obuf and the assertion macro header.
//
// One command request is taken at a time; s_tready is high only while the block
// is idle. Enable, disable, update, set-kernel-alarm and unknown commands give
// a single result. Register walks the registered flags one slot per cycle.
// Alarm tick and fire-all walk the deadline RAM through its one read port, one
// slot per cycle unless a fired result is blocked, then drain the held fired
// result and the alarm program result (fire-all with no alarm left ends on its
// last fired result, or on an acknowledge if nothing fired). Every result request
// leaves through an output register. No clearing pass is needed after reset.
`include "multiplexed_alarm_scheduler_top_assert.svh"

module multiplexed_alarm_scheduler_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // task_index[3:0], period[31:0], now_time[31:0], kernel_alarm_value[31:0],
    // kernel_irq_enabled, 3'b0
    input  logic [masch_pkg::S_DATA_W-1:0] s_tdata,
    // action[2:0]
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // error_code, task_index_res[3:0], alarm_time[31:0], alarm_enable, 2'b0
    output logic [masch_pkg::M_DATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast
);
    import masch_pkg::*;

    state_t state_reg, state_next;
    logic [SLOTS-1:0]  en_reg, en_next;
    logic [SLOTS-1:0]  regd_reg, regd_next;
    logic [TIME_W-1:0] next_alarm_reg, next_alarm_next;
    logic [TIME_W-1:0] kernel_alarm_reg, kernel_alarm_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] best_reg, best_next;
    logic              fire_all_reg, fire_all_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [SLOT_W-1:0] ev_idx_reg, ev_idx_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [SLOT_W-1:0] hold_idx_reg, hold_idx_next;
    logic              any_fire_reg, any_fire_next;
    res_t              res_reg, res_next;

    logic [IDX_W-1:0]  in_idx;
    logic [TIME_W-1:0] in_period;
    logic [TIME_W-1:0] in_now;
    logic [TIME_W-1:0] in_kval;
    logic              in_kirq;
    action_t           in_act;
    logic              accept;
    logic [SLOT_W-1:0] slot_sel;
    logic              slot_ok;

    logic [SLOT_W-1:0] scan_slot;
    logic              scan_end;
    logic              scan_done;
    logic              sleep_hit;
    logic              next_off;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [TIME_W-1:0] ram_wdata;
    logic              ram_re;
    logic [TIME_W-1:0] ram_rdata;

    logic              ev_act;
    logic              ev_fire;
    logic              ev_keep;
    logic              ev_block;

    logic              push;
    res_t              push_res;
    logic              can_take;

    assign in_idx    = s_tdata[3:0];
    assign in_period = s_tdata[35:4];
    assign in_now    = s_tdata[67:36];
    assign in_kval   = s_tdata[99:68];
    assign in_kirq   = s_tdata[100];
    assign in_act    = action_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_sel  = idx_to_slot(in_idx);
    assign slot_ok   = idx_in_range(in_idx) && regd_reg[slot_sel];

    assign scan_slot = cnt_reg[SLOT_W-1:0];
    assign scan_end  = (cnt_reg == CNT_W'(SLOTS));
    assign scan_done = scan_end && !ev_valid_reg;
    assign sleep_hit = (kernel_alarm_reg == next_alarm_reg);
    assign next_off  = (next_alarm_reg == NO_ALARM);

    assign ev_act   = ev_valid_reg && en_reg[ev_idx_reg] && regd_reg[ev_idx_reg];
    assign ev_fire  = ev_act && (fire_all_reg || (ram_rdata <= now_reg));
    assign ev_keep  = ev_act && !ev_fire;
    assign ev_block = ev_fire && hold_valid_reg && !can_take;

    masch_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOTS),
        .AW    (SLOT_W)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_slot),
        .rdata (ram_rdata)
    );

    masch_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res      (push_res),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_act)
                        ACT_REGISTER: state_next = ST_REG_SCAN;
                        ACT_TICK:     state_next = ST_SLEEP;
                        ACT_FIRE_ALL: state_next = ST_SCAN;
                        default:      state_next = ST_SINGLE;
                    endcase
                end
            end
            ST_REG_SCAN:
            begin
                if (!regd_reg[scan_slot] || (cnt_reg == CNT_W'(SLOTS - 1)))
                begin
                    state_next = ST_SINGLE;
                end
            end
            ST_SINGLE:
            begin
                if (can_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SLEEP:
            begin
                if (!sleep_hit || can_take)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg || can_take)
                begin
                    state_next = ST_PROG;
                end
            end
            ST_PROG:
            begin
                if ((fire_all_reg && next_off && any_fire_reg) || can_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and result requests
    always_comb
    begin
        en_next           = en_reg;
        regd_next         = regd_reg;
        next_alarm_next   = next_alarm_reg;
        kernel_alarm_next = kernel_alarm_reg;
        now_next          = now_reg;
        best_next         = best_reg;
        fire_all_next     = fire_all_reg;
        cnt_next          = cnt_reg;
        ev_valid_next     = ev_valid_reg;
        ev_idx_next       = ev_idx_reg;
        hold_valid_next   = hold_valid_reg;
        hold_idx_next     = hold_idx_reg;
        any_fire_next     = any_fire_reg;
        res_next          = res_reg;
        ram_we            = 1'b0;
        ram_waddr         = slot_sel;
        ram_wdata         = NO_ALARM;
        ram_re            = 1'b0;
        push              = 1'b0;
        push_res          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    now_next        = in_now;
                    fire_all_next   = (in_act == ACT_FIRE_ALL);
                    cnt_next        = '0;
                    ev_valid_next   = 1'b0;
                    hold_valid_next = 1'b0;
                    any_fire_next   = 1'b0;
                    best_next       = NO_ALARM;
                    res_next        = '0;
                    res_next.last   = 1'b1;
                    case (in_act)
                        ACT_REGISTER, ACT_TICK, ACT_FIRE_ALL:
                        begin
                            res_next.kind = KIND_ACK;
                        end
                        ACT_ENABLE, ACT_DISABLE:
                        begin
                            if (slot_ok)
                            begin
                                en_next[slot_sel] = (in_act == ACT_ENABLE);
                                res_next.kind     = KIND_ACK;
                            end
                            else
                            begin
                                res_next.kind       = KIND_ERROR;
                                res_next.error_code = ERR_INVALID;
                            end
                        end
                        ACT_UPDATE:
                        begin
                            if (slot_ok && (in_period != '0))
                            begin
                                ram_we            = 1'b1;
                                ram_wdata         = in_now + in_period;
                                en_next[slot_sel] = 1'b1;
                                res_next.kind     = KIND_ACK;
                            end
                            else
                            begin
                                res_next.kind       = KIND_ERROR;
                                res_next.error_code = ERR_INVALID;
                            end
                        end
                        ACT_SET_KERNEL:
                        begin
                            kernel_alarm_next = in_kirq ? in_kval : NO_ALARM;
                            res_next.kind     = KIND_ACK;
                        end
                        default:
                        begin
                            res_next.kind       = KIND_ERROR;
                            res_next.error_code = ERR_INVALID;
                        end
                    endcase
                end
            end
            ST_REG_SCAN:
            begin
                if (!regd_reg[scan_slot])
                begin
                    regd_next[scan_slot]    = 1'b1;
                    en_next[scan_slot]      = 1'b0;
                    ram_we                  = 1'b1;
                    ram_waddr               = scan_slot;
                    ram_wdata               = NO_ALARM;
                    res_next.kind           = KIND_ACK;
                    res_next.task_index_res = slot_to_res(scan_slot);
                end
                else if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    res_next.kind       = KIND_ERROR;
                    res_next.error_code = ERR_NO_SLOT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SINGLE:
            begin
                push     = 1'b1;
                push_res = res_reg;
            end
            ST_SLEEP:
            begin
                if (sleep_hit)
                begin
                    push          = 1'b1;
                    push_res.kind = KIND_SLEEP;
                end
            end
            ST_SCAN:
            begin
                if (!ev_block)
                begin
                    if (ev_fire)
                    begin
                        en_next[ev_idx_reg] = 1'b0;
                        hold_valid_next     = 1'b1;
                        hold_idx_next       = ev_idx_reg;
                        any_fire_next       = 1'b1;
                        if (hold_valid_reg)
                        begin
                            push                    = 1'b1;
                            push_res.kind           = KIND_FIRED;
                            push_res.task_index_res = slot_to_res(hold_idx_reg);
                        end
                    end
                    if (ev_keep && (ram_rdata < best_reg))
                    begin
                        best_next = ram_rdata;
                    end
                    if (!scan_end)
                    begin
                        ram_re        = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = scan_slot;
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end
                    if (scan_done)
                    begin
                        next_alarm_next = (best_reg > kernel_alarm_reg) ?
                                          kernel_alarm_reg : best_reg;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (hold_valid_reg)
                begin
                    push                    = 1'b1;
                    push_res.kind           = KIND_FIRED;
                    push_res.task_index_res = slot_to_res(hold_idx_reg);
                    push_res.last           = fire_all_reg && next_off;
                    if (can_take)
                    begin
                        hold_valid_next = 1'b0;
                    end
                end
            end
            ST_PROG:
            begin
                if (!next_off)
                begin
                    push                  = 1'b1;
                    push_res.kind         = KIND_PROG;
                    push_res.alarm_time   = next_alarm_reg;
                    push_res.alarm_enable = 1'b1;
                    push_res.last         = 1'b1;
                end
                else if (!fire_all_reg)
                begin
                    push                  = 1'b1;
                    push_res.kind         = KIND_PROG;
                    push_res.alarm_time   = NO_ALARM;
                    push_res.last         = 1'b1;
                end
                else if (!any_fire_reg)
                begin
                    push          = 1'b1;
                    push_res.kind = KIND_ACK;
                    push_res.last = 1'b1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            en_reg           <= '0;
            regd_reg         <= '0;
            next_alarm_reg   <= NO_ALARM;
            kernel_alarm_reg <= NO_ALARM;
            fire_all_reg     <= 1'b0;
            cnt_reg          <= '0;
            ev_valid_reg     <= 1'b0;
            hold_valid_reg   <= 1'b0;
            any_fire_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            en_reg           <= en_next;
            regd_reg         <= regd_next;
            next_alarm_reg   <= next_alarm_next;
            kernel_alarm_reg <= kernel_alarm_next;
            fire_all_reg     <= fire_all_next;
            cnt_reg          <= cnt_next;
            ev_valid_reg     <= ev_valid_next;
            hold_valid_reg   <= hold_valid_next;
            any_fire_reg     <= any_fire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        best_reg     <= best_next;
        ev_idx_reg   <= ev_idx_next;
        hold_idx_reg <= hold_idx_next;
        res_reg      <= res_next;
    end

    `MASCH_ASSERT_NOW(a_idle_no_hold, state_reg == ST_IDLE, !hold_valid_reg && !ev_valid_reg, "fired result held while idle")
    `MASCH_ASSERT_NEXT(a_fire_clears_enable, (state_reg == ST_SCAN) && ev_fire && !ev_block, !en_reg[$past(ev_idx_reg)] && hold_valid_reg, "fired slot still enabled")
    `MASCH_ASSERT_NEXT(a_register_claims, (state_reg == ST_REG_SCAN) && !regd_reg[scan_slot], regd_reg[$past(scan_slot)] && (state_reg == ST_SINGLE), "register did not claim slot")
    `MASCH_ASSERT_NOW(a_scan_count, (state_reg == ST_SCAN) || (state_reg == ST_REG_SCAN), cnt_reg <= CNT_W'(SLOTS), "scan counter past slot count")

endmodule

// File: rtl/masch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module masch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/masch_obuf.sv
// Output register stage: holds one result request for the master stream.
// Depends on masch_pkg.
module masch_obuf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  masch_pkg::res_t               res,
    output logic                          can_take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // error_code, task_index_res[3:0], alarm_time[31:0], alarm_enable, 2'b0
    output logic [masch_pkg::M_DATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast
);
    import masch_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign can_take = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push && can_take)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && can_take)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, data_reg.alarm_enable, data_reg.alarm_time,
                       data_reg.task_index_res, data_reg.error_code};
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.last;

endmodule

// File: verif/multiplexed_alarm_scheduler_top_test.sv
// Testbench for multiplexed_alarm_scheduler_top: directed table then random command requests,
// every result checked against a table row or an in-bench model of slot table and RTC alarm.
// Depends on masch_pkg and the scheduler RTL only.
`timescale 1ns / 100ps

module multiplexed_alarm_scheduler_top_test;
    import masch_pkg::*;

    localparam int RAND_ITEMS  = 190;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 40;
    localparam int DIR_ROWS    = 24;

    typedef struct {
        logic [2:0]  act;
        logic [3:0]  idx;
        logic [31:0] period;
        logic [31:0] now;
        logic [31:0] kval;
        logic        kirq;
        int          reps;
        bit          typed;
        kind_t       kind;
        logic        err;
        logic [3:0]  slot;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;

    // model of the slot table
    logic [TIME_W-1:0] slot_deadline [SLOTS];
    logic              slot_armed    [SLOTS];
    logic              slot_taken    [SLOTS];
    logic [TIME_W-1:0] rtc_next_alarm;
    logic [TIME_W-1:0] krn_alarm;

    res_t      step_res [$];
    res_t      expected_res [$];
    res_t      want;
    stim_row_t dir_tbl [DIR_ROWS];

    int          mismatch_cnt = 0;
    int          result_cnt = 0;
    int          cycle_cnt = 0;
    bit          no_idle;
    logic [31:0] rtc_now;

    multiplexed_alarm_scheduler_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_v);
        $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                 $time, result_cnt, what, got, exp_v);
        mismatch_cnt++;
    endtask

    function automatic res_t make_res(input kind_t k, input logic err, input logic [3:0] slot,
                                      input logic [31:0] at, input logic en);
        res_t r;
        r.kind           = k;
        r.error_code     = err;
        r.task_index_res = slot;
        r.alarm_time     = at;
        r.alarm_enable   = en;
        r.last           = 1'b0;
        return r;
    endfunction

    task automatic recompute_alarm();
        logic [TIME_W-1:0] best;
        best = NO_ALARM;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_armed[i] && slot_taken[i] && slot_deadline[i] < best)
                best = slot_deadline[i];
        end
        if (best > krn_alarm)
            best = krn_alarm;
        rtc_next_alarm = best;
    endtask

    task automatic predict_alarm_step(input logic [2:0] act, input logic [3:0] idx,
                                      input logic [31:0] period, input logic [31:0] now,
                                      input logic [31:0] kval, input logic kirq);
        int  found;
        step_res.delete();
        found = -1;
        case (act)
            ACT_REGISTER:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (found < 0 && !slot_taken[i])
                        found = i;
                end
                if (found < 0)
                    step_res.push_back(make_res(KIND_ERROR, ERR_NO_SLOT, 4'd0, '0, 1'b0));
                else
                begin
                    slot_taken[found]    = 1'b1;
                    slot_armed[found]    = 1'b0;
                    slot_deadline[found] = NO_ALARM;
                    step_res.push_back(make_res(KIND_ACK, 1'b0, 4'(found), '0, 1'b0));
                end
            end
            ACT_ENABLE, ACT_DISABLE:
            begin
                if (!(int'(idx) < SLOTS && slot_taken[idx]))
                    step_res.push_back(make_res(KIND_ERROR, ERR_INVALID, 4'd0, '0, 1'b0));
                else
                begin
                    slot_armed[idx] = (act == ACT_ENABLE);
                    step_res.push_back(make_res(KIND_ACK, 1'b0, 4'd0, '0, 1'b0));
                end
            end
            ACT_UPDATE:
            begin
                if (!(int'(idx) < SLOTS && slot_taken[idx]) || period == '0)
                    step_res.push_back(make_res(KIND_ERROR, ERR_INVALID, 4'd0, '0, 1'b0));
                else
                begin
                    slot_deadline[idx] = now + period;
                    slot_armed[idx]    = 1'b1;
                    step_res.push_back(make_res(KIND_ACK, 1'b0, 4'd0, '0, 1'b0));
                end
            end
            ACT_TICK:
            begin
                if (krn_alarm == rtc_next_alarm)
                    step_res.push_back(make_res(KIND_SLEEP, 1'b0, 4'd0, '0, 1'b0));
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_armed[i] && slot_taken[i] && slot_deadline[i] <= now)
                    begin
                        slot_armed[i] = 1'b0;
                        step_res.push_back(make_res(KIND_FIRED, 1'b0, 4'(i), '0, 1'b0));
                    end
                end
                recompute_alarm();
                if (rtc_next_alarm != NO_ALARM)
                    step_res.push_back(make_res(KIND_PROG, 1'b0, 4'd0, rtc_next_alarm, 1'b1));
                else
                    step_res.push_back(make_res(KIND_PROG, 1'b0, 4'd0, NO_ALARM, 1'b0));
            end
            ACT_SET_KERNEL:
            begin
                krn_alarm = kirq ? kval : NO_ALARM;
                step_res.push_back(make_res(KIND_ACK, 1'b0, 4'd0, '0, 1'b0));
            end
            ACT_FIRE_ALL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_armed[i] && slot_taken[i])
                    begin
                        slot_armed[i] = 1'b0;
                        step_res.push_back(make_res(KIND_FIRED, 1'b0, 4'(i), '0, 1'b0));
                    end
                end
                recompute_alarm();
                if (rtc_next_alarm != NO_ALARM)
                    step_res.push_back(make_res(KIND_PROG, 1'b0, 4'd0, rtc_next_alarm, 1'b1));
                if (step_res.size() == 0)
                    step_res.push_back(make_res(KIND_ACK, 1'b0, 4'd0, '0, 1'b0));
            end
            default:
                step_res.push_back(make_res(KIND_ERROR, ERR_INVALID, 4'd0, '0, 1'b0));
        endcase
        step_res[step_res.size()-1].last = 1'b1;
    endtask

    // drive one command request, predict at acceptance, then maybe idle
    task automatic issue_request(input logic [2:0] act, input logic [3:0] idx,
                                 input logic [31:0] period, input logic [31:0] now,
                                 input logic [31:0] kval, input logic kirq,
                                 input bit typed, input res_t typed_res);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, kirq, kval, now, period, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_alarm_step(act, idx, period, now, kval, kirq);
        if (typed)
            expected_res.push_back(typed_res);
        else
            foreach (step_res[i])
                expected_res.push_back(step_res[i]);
        if (!no_idle && $urandom_range(0, 99) < 24)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (no_idle)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 24);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_res.size() == 0)
                report_mismatch("no result expected, kind", 32'(m_tuser), 32'd0);
            else
            begin
                want = expected_res.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[0] !== want.error_code)
                    report_mismatch("error_code", 32'(m_tdata[0]), 32'(want.error_code));
                if (m_tdata[4:1] !== want.task_index_res)
                    report_mismatch("task_index_res", 32'(m_tdata[4:1]),
                                    32'(want.task_index_res));
                if (m_tdata[36:5] !== want.alarm_time)
                    report_mismatch("alarm_time", m_tdata[36:5], want.alarm_time);
                if (m_tdata[37] !== want.alarm_enable)
                    report_mismatch("alarm_enable", 32'(m_tdata[37]), 32'(want.alarm_enable));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
            result_cnt++;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]  act;
        logic [3:0]  idx;
        logic [31:0] period;
        logic [31:0] now;
        logic [31:0] kval;
        logic        kirq;
        int          pick;
        res_t        row_res;

        no_idle      = 1'b0;
        rtc_now      = 32'd1000;
        row_res      = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;

        for (int i = 0; i < SLOTS; i++)
        begin
            slot_deadline[i] = NO_ALARM;
            slot_armed[i]    = 1'b0;
            slot_taken[i]    = 1'b0;
        end
        rtc_next_alarm = NO_ALARM;
        krn_alarm      = NO_ALARM;

        // act, idx, period, now, kval, kirq, reps, typed, kind, err, slot
        dir_tbl = '{
            '{ACT_TICK,       4'd0,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_FIRE_ALL,   4'd0,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ACK,   1'b0,        4'd0},
            '{ACT_ENABLE,     4'd15, 32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ERROR, ERR_INVALID, 4'd0},
            '{ACT_DISABLE,    4'd0,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ERROR, ERR_INVALID, 4'd0},
            '{ACT_UPDATE,     4'd7,  32'd5,        32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ERROR, ERR_INVALID, 4'd0},
            '{3'b111,         4'hf,  32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 1,
               1'b1, KIND_ERROR, ERR_INVALID, 4'd0},
            '{ACT_REGISTER,   4'd0,  32'd0,        32'd0,        32'd0,        1'b0, SLOTS,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_REGISTER,   4'd0,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ERROR, ERR_NO_SLOT, 4'd0},
            '{ACT_UPDATE,     4'd0,  32'd0,        32'd1234,     32'd0,        1'b0, 1,
               1'b1, KIND_ERROR, ERR_INVALID, 4'd0},
            '{ACT_UPDATE,     4'd0,  32'h200,      32'hffffff00, 32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_UPDATE,     4'd15, 32'hffffffff, 32'd0,        32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_UPDATE,     4'd5,  32'd50,       32'd100,      32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_SET_KERNEL, 4'd0,  32'd0,        32'd0,        32'h1000,     1'b1, 1,
               1'b1, KIND_ACK,   1'b0,        4'd0},
            '{ACT_TICK,       4'd0,  32'd0,        32'h100,      32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_TICK,       4'd0,  32'd0,        32'hffffffff, 32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_SET_KERNEL, 4'd0,  32'd0,        32'd0,        32'hdeadbeef, 1'b0, 1,
               1'b1, KIND_ACK,   1'b0,        4'd0},
            '{ACT_ENABLE,     4'd3,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ACK,   1'b0,        4'd0},
            '{ACT_DISABLE,    4'd3,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ACK,   1'b0,        4'd0},
            '{ACT_ENABLE,     4'd4,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ACK,   1'b0,        4'd0},
            '{ACT_FIRE_ALL,   4'd0,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_SET_KERNEL, 4'd0,  32'd0,        32'd0,        32'h5000,     1'b1, 1,
               1'b1, KIND_ACK,   1'b0,        4'd0},
            '{ACT_UPDATE,     4'd2,  32'd10,       32'd0,        32'd0,        1'b0, 1,
               1'b1, KIND_ACK,   1'b0,        4'd0},
            '{ACT_FIRE_ALL,   4'd0,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0},
            '{ACT_TICK,       4'd0,  32'd0,        32'd0,        32'd0,        1'b0, 1,
               1'b0, KIND_ACK,   1'b0,        4'd0}
        };

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[r])
        begin
            for (int k = 0; k < dir_tbl[r].reps; k++)
            begin
                row_res = make_res(dir_tbl[r].kind, dir_tbl[r].err, dir_tbl[r].slot, '0, 1'b0);
                row_res.last = 1'b1;
                issue_request(dir_tbl[r].act, dir_tbl[r].idx, dir_tbl[r].period,
                              dir_tbl[r].now, dir_tbl[r].kval, dir_tbl[r].kirq,
                              dir_tbl[r].typed, row_res);
            end
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            no_idle = (n >= 80 && n < 140);
            if (n == 160)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_res.size() != 0)
                    @(posedge clk);
            end
            idx    = 4'($urandom_range(0, 15));
            period = $urandom();
            now    = $urandom();
            kval   = $urandom();
            kirq   = 1'($urandom_range(0, 1));
            pick   = $urandom_range(0, 99);
            if (pick < 35)
            begin
                act = ACT_UPDATE;
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    period = '0;
                else if (pick < 80)
                    period = $urandom_range(1, 64);
                if ($urandom_range(0, 99) < 85)
                    now = rtc_now;
            end
            else if (pick < 55)
            begin
                act = ACT_TICK;
                rtc_now = rtc_now + $urandom_range(0, 40);
                if ($urandom_range(0, 99) < 90)
                    now = rtc_now;
            end
            else if (pick < 67)
                act = ($urandom_range(0, 1) != 0) ? ACT_ENABLE : ACT_DISABLE;
            else if (pick < 77)
            begin
                act = ACT_SET_KERNEL;
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    kval = rtc_next_alarm;
                else if (pick < 80)
                    kval = rtc_now + $urandom_range(0, 100);
            end
            else if (pick < 87)
                act = ACT_FIRE_ALL;
            else if (pick < 93)
                act = ACT_REGISTER;
            else
                act = 3'b111;
            issue_request(act, idx, period, now, kval, kirq, 1'b0, row_res);
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (expected_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
